[design/sphc_pkg.sv]
package sphc_pkg;

  // Saturation value of the hit counter and reset value of the limits.
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  // Default depth of the segment start table.
  localparam int MAX_SEGMENTS_DEFAULT = 64;

  // Field widths of the stream words.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 6;
  localparam int WORD_W  = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SEG_COUNT_W = 7;

  // Command codes carried in the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_ENTRY = 2'd0,
    CMD_BEGIN_PASS  = 2'd1,
    CMD_DOCUMENT    = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_DOC        = 2'd0,
    REG_END_DOC          = 2'd1,
    REG_HITS_PER_SEGMENT = 2'd2,
    REG_SEGMENT_COUNT    = 2'd3
  } cfg_reg_t;

endpackage

[design/segment_pruned_hit_collector_unit.sv]
// Segment-pruned hit collector. Input words arrive in an input register and
// are decided from there against the pass state and the segment start table
// once the output register can take a word; the decision registers a
// collected hit in the output register, and the unit takes one word per cycle
// as long as the output side drains. The rate is set by the single decision
// stage, in which its compares and the two-port table read settle. The table
// is a RAM with one write port and two registered read ports that are
// addressed with the next segment cursor, so the current and following
// segment starts are ready when the next document arrives. Table entries are
// undefined until written; there is no clearing pass after reset.
// Configuration is taken every cycle and should only be written while the
// unit is idle.
module segment_pruned_hit_collector_unit #(
  parameter int MAX_SEGMENTS = sphc_pkg::MAX_SEGMENTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input word stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata: segment_index[5:0], segment_start[37:6], doc_number[69:38],
  // doc_score[101:70], zero fill[103:102]
  input  logic [sphc_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: command[1:0]
  input  logic [sphc_pkg::CMD_W-1:0]       s_tuser,
  // Hit stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tdata: hit_doc[31:0], hit_score[63:32]
  output logic [sphc_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sphc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sphc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // Configuration registers.
  logic [31:0]                       start_doc;
  logic [31:0]                       end_doc;
  logic [31:0]                       hits_per_segment;
  logic [sphc_pkg::SEG_COUNT_W-1:0]  segment_count;

  // Input register.
  logic                              in_valid;
  sphc_pkg::cmd_t                    in_cmd;
  logic [sphc_pkg::INDEX_W-1:0]      in_index;
  logic [31:0]                       in_seg_start;
  logic [31:0]                       in_doc;
  logic [31:0]                       in_score;

  // Pass state.
  phase_t                            phase, phase_next;
  logic [31:0]                       seek_target, seek_target_next;
  logic                              seek_for_segment, seek_for_segment_next;
  logic [CW-1:0]                     cursor, cursor_next;
  logic [31:0]                       seg_limit, seg_limit_next;
  logic [31:0]                       hits, hits_next;
  logic                              pruning_off, pruning_off_next;

  // Segment table and its registered read data.
  logic [31:0]                       seg_table [MAX_SEGMENTS];
  logic [31:0]                       rd_cur;
  logic [31:0]                       rd_next;
  logic [AW-1:0]                     raddr_cur;
  logic [AW-1:0]                     raddr_next;
  logic                              tbl_we;
  logic [AW-1:0]                     tbl_waddr;

  // Decision signals.
  logic                              fire;
  logic                              emit;
  logic [CW-1:0]                     live_n;
  logic [31:0]                       thresh;
  logic                              over;
  logic [CW:0]                       cursor_inc;
  logic [31:0]                       new_limit;
  logic [31:0]                       hits_sat_inc;

  // Handshakes: the decision stage runs when the output register can take a word.
  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_doc        <= '0;
      end_doc          <= sphc_pkg::U32_MAX;
      hits_per_segment <= sphc_pkg::U32_MAX;
      segment_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sphc_pkg::cfg_reg_t'(cfg_index))
        sphc_pkg::REG_START_DOC:        start_doc        <= cfg_data;
        sphc_pkg::REG_END_DOC:          end_doc          <= cfg_data;
        sphc_pkg::REG_HITS_PER_SEGMENT: hits_per_segment <= cfg_data;
        sphc_pkg::REG_SEGMENT_COUNT:
          segment_count <= cfg_data[sphc_pkg::SEG_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Live segment count, clipped to the table depth.
  always_comb begin
    if (32'(segment_count) > 32'(MAX_SEGMENTS)) begin
      live_n = MAX_CNT;
    end else begin
      live_n = CW'(segment_count);
    end
  end

  assign thresh       = pruning_off ? sphc_pkg::U32_MAX : hits_per_segment;
  assign over         = (hits >= thresh) || (in_doc >= seg_limit);
  assign cursor_inc   = {1'b0, cursor} + (CW+1)'(1);
  assign new_limit    = (cursor_inc < {1'b0, live_n}) ? rd_next : end_doc;
  assign hits_sat_inc = (hits == sphc_pkg::U32_MAX) ? hits : hits + 32'd1;
  assign tbl_waddr    = AW'(in_index);

  // Next-state logic for one input word.
  always_comb begin
    phase_next            = phase;
    seek_target_next      = seek_target;
    seek_for_segment_next = seek_for_segment;
    cursor_next           = cursor;
    seg_limit_next        = seg_limit;
    hits_next             = hits;
    pruning_off_next      = pruning_off;
    emit                  = 1'b0;
    tbl_we                = 1'b0;
    if (fire) begin
      unique case (in_cmd)
        sphc_pkg::CMD_WRITE_ENTRY: begin
          tbl_we = 32'(in_index) < 32'(MAX_SEGMENTS);
        end
        sphc_pkg::CMD_BEGIN_PASS: begin
          phase_next            = PH_SEEK;
          seek_target_next      = start_doc;
          seek_for_segment_next = 1'b0;
          cursor_next           = '0;
          seg_limit_next        = '0;
          hits_next             = '0;
          pruning_off_next      = 1'b0;
        end
        sphc_pkg::CMD_DOCUMENT: begin
          if (phase == PH_SEEK && in_doc >= seek_target && seek_for_segment) begin
            // Landed on a segment start: collected without the end check.
            seek_for_segment_next = 1'b0;
            phase_next            = PH_COLLECT;
            hits_next             = 32'd1;
            emit                  = 1'b1;
          end else if ((phase == PH_SEEK && in_doc >= seek_target) ||
                       phase == PH_COLLECT) begin
            if (!over) begin
              phase_next = PH_COLLECT;
              hits_next  = hits_sat_inc;
              emit       = 1'b1;
            end else if (in_doc >= end_doc) begin
              phase_next = PH_DONE;
            end else if (live_n == '0) begin
              // No table loaded: only end_doc limits the pass.
              pruning_off_next = 1'b1;
              seg_limit_next   = end_doc;
              phase_next       = PH_COLLECT;
              hits_next        = 32'd1;
              emit             = 1'b1;
            end else if (cursor >= live_n) begin
              phase_next = PH_DONE;
            end else begin
              // Move on to the next segment.
              cursor_next    = cursor_inc[CW-1:0];
              seg_limit_next = new_limit;
              if (in_doc < rd_cur) begin
                seek_target_next      = rd_cur;
                seek_for_segment_next = 1'b1;
                phase_next            = PH_SEEK;
                hits_next             = '0;
              end else begin
                phase_next = PH_COLLECT;
                hits_next  = 32'd1;
                emit       = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Table read addresses follow the cursor that the next word will see.
  assign raddr_cur  = rst ? '0 : AW'(cursor_next);
  assign raddr_next = rst ? AW'(1) : AW'(cursor_next + CW'(1));

  // Segment table: one write port, two registered read ports with write bypass.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      seg_table[tbl_waddr] <= in_seg_start;
    end
    if (tbl_we && tbl_waddr == raddr_cur) begin
      rd_cur <= in_seg_start;
    end else begin
      rd_cur <= seg_table[raddr_cur];
    end
    if (tbl_we && tbl_waddr == raddr_next) begin
      rd_next <= in_seg_start;
    end else begin
      rd_next <= seg_table[raddr_next];
    end
  end

  // Input register, pass state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      m_tvalid         <= 1'b0;
      phase            <= PH_SEEK;
      seek_target      <= '0;
      seek_for_segment <= 1'b0;
      cursor           <= '0;
      seg_limit        <= '0;
      hits             <= '0;
      pruning_off      <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        m_tvalid <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      phase            <= phase_next;
      seek_target      <= seek_target_next;
      seek_for_segment <= seek_for_segment_next;
      cursor           <= cursor_next;
      seg_limit        <= seg_limit_next;
      hits             <= hits_next;
      pruning_off      <= pruning_off_next;
    end
    if (s_tvalid && s_tready) begin
      in_cmd       <= sphc_pkg::cmd_t'(s_tuser);
      in_index     <= s_tdata[5:0];
      in_seg_start <= s_tdata[37:6];
      in_doc       <= s_tdata[69:38];
      in_score     <= s_tdata[101:70];
    end
    if (fire && emit) begin
      m_tdata <= {in_score, in_doc};
    end
  end

  // A segment skip is only pending while seeking.
  assert property (@(posedge clk) disable iff (rst)
    seek_for_segment |-> phase == PH_SEEK)
    else $error("segment skip pending outside the seek phase");

  // Beginning a pass rewinds the segment walk.
  assert property (@(posedge clk) disable iff (rst)
    fire && in_cmd == sphc_pkg::CMD_BEGIN_PASS |=>
      phase == PH_SEEK && cursor == '0 && hits == '0 && !pruning_off)
    else $error("pass state not rewound by begin command");

  // The cursor steps by at most one segment per word, or rewinds.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> cursor == $past(cursor) || cursor == $past(cursor) + CW'(1) ||
             cursor == '0)
    else $error("segment cursor jumped");

  // The cursor never passes the table depth.
  assert property (@(posedge clk) disable iff (rst)
    cursor <= MAX_CNT)
    else $error("segment cursor beyond table depth");

  // The input side stalls only while a word waits behind a stalled hit.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked hit");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_SEG = sphc_pkg::MAX_SEGMENTS_DEFAULT;
  // Cycles allowed after the last expected hit for words that make no hit.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {
    PH_SEEKING    = 2'd0,
    PH_COLLECTING = 2'd1,
    PH_DONE       = 2'd2
  } pass_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [sphc_pkg::IN_DATA_W-1:0] s_tdata;
  logic [sphc_pkg::CMD_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [sphc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [sphc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sphc_pkg::CFG_DATA_W-1:0] cfg_data;

  // Registers and pass state mirrored from the collector.
  logic [31:0] start_doc_m = '0;
  logic [31:0] end_doc_m = sphc_pkg::U32_MAX;
  logic [31:0] hits_cap_m = sphc_pkg::U32_MAX;
  logic [6:0] seg_count_m = '0;
  pass_phase_t phase_m = PH_SEEKING;
  logic [31:0] seek_target_m = '0;
  bit seek_for_seg_m = 1'b0;
  int cursor_m = 0;
  logic [31:0] seg_limit_m = '0;
  logic [31:0] seg_hits_m = '0;
  bit no_pruning_m = 1'b0;
  logic [31:0] seg_start_m [MAX_SEG];

  // Expected hits, hit_score in the upper half and hit_doc in the lower.
  logic [63:0] pending_hits [$];
  int mismatches = 0;
  int words_sent = 0;
  int src_idle_pct = 10;
  int sink_stall_pct = 50;
  int cycles = 0;

  segment_pruned_hit_collector_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stop a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The hit side stalls at random.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? sphc_pkg::U32_MAX : sum[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : 32'd0;
  endfunction

  // The hit count saturates rather than wrapping.
  function automatic void count_hit();
    if (seg_hits_m != sphc_pkg::U32_MAX) seg_hits_m++;
  endfunction

  // Decide a document that is in range of the current pass; returns 1 on a hit.
  function automatic bit judge_document(input logic [31:0] doc);
    logic [31:0] cap;
    logic [31:0] seg_first;
    int live;
    cap = no_pruning_m ? sphc_pkg::U32_MAX : hits_cap_m;
    if (seg_hits_m >= cap || doc >= seg_limit_m) begin
      live = (seg_count_m > MAX_SEG) ? MAX_SEG : int'(seg_count_m);
      if (doc >= end_doc_m) begin
        phase_m = PH_DONE;
        return 1'b0;
      end
      if (live == 0) begin
        no_pruning_m = 1'b1;
        seg_limit_m = end_doc_m;
      end else if (cursor_m >= live) begin
        phase_m = PH_DONE;
        return 1'b0;
      end else begin
        seg_first = seg_start_m[cursor_m];
        seg_limit_m = (cursor_m + 1 < live) ? seg_start_m[cursor_m + 1] : end_doc_m;
        cursor_m++;
        seg_hits_m = '0;
        // The document lies before the new segment: wait for its start.
        if (doc < seg_first) begin
          seek_target_m = seg_first;
          seek_for_seg_m = 1'b1;
          phase_m = PH_SEEKING;
          return 1'b0;
        end
      end
      seg_hits_m = '0;
    end
    phase_m = PH_COLLECTING;
    count_hit();
    return 1'b1;
  endfunction

  // Advance the mirrored state by one accepted word; returns 1 when it makes a hit.
  function automatic bit predict_hit(input sphc_pkg::cmd_t cmd, input logic [5:0] idx,
                                     input logic [31:0] seg_start, input logic [31:0] doc);
    case (cmd)
      sphc_pkg::CMD_WRITE_ENTRY: begin
        seg_start_m[idx] = seg_start;
      end
      sphc_pkg::CMD_BEGIN_PASS: begin
        phase_m = PH_SEEKING;
        seek_target_m = start_doc_m;
        seek_for_seg_m = 1'b0;
        cursor_m = 0;
        seg_limit_m = '0;
        seg_hits_m = '0;
        no_pruning_m = 1'b0;
      end
      sphc_pkg::CMD_DOCUMENT: begin
        if (phase_m == PH_SEEKING) begin
          if (doc < seek_target_m) return 1'b0;
          // A document reached by a segment skip is taken without the end check.
          if (seek_for_seg_m) begin
            seek_for_seg_m = 1'b0;
            phase_m = PH_COLLECTING;
            seg_hits_m = '0;
            count_hit();
            return 1'b1;
          end
          return judge_document(doc);
        end
        if (phase_m == PH_COLLECTING) return judge_document(doc);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Send one word, idling the sender cycle by cycle before it, and record any hit it makes.
  task automatic send_word(input sphc_pkg::cmd_t cmd, input logic [5:0] idx,
                           input logic [31:0] seg_start, input logic [31:0] doc,
                           input logic [31:0] score);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, score, doc, seg_start, idx};
    do @(posedge clk); while (!s_tready);
    if (predict_hit(cmd, idx, seg_start, doc)) pending_hits.push_back({score, doc});
    words_sent++;
  endtask

  task automatic send_doc(input logic [31:0] doc, input logic [31:0] score);
    send_word(sphc_pkg::CMD_DOCUMENT, 6'($urandom_range(63)), $urandom, doc, score);
  endtask

  task automatic send_cmd(input sphc_pkg::cmd_t cmd);
    send_word(cmd, 6'($urandom_range(63)), $urandom, $urandom, $urandom);
  endtask

  // Write a register once the stream is drained and the unit has gone quiet.
  task automatic set_reg(input sphc_pkg::cfg_reg_t r, input logic [31:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      sphc_pkg::REG_START_DOC:        start_doc_m = value;
      sphc_pkg::REG_END_DOC:          end_doc_m = value;
      sphc_pkg::REG_HITS_PER_SEGMENT: hits_cap_m = value;
      sphc_pkg::REG_SEGMENT_COUNT:    seg_count_m = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pass_regs(input logic [31:0] first, input logic [31:0] stop,
                               input logic [31:0] cap, input logic [6:0] count);
    set_reg(sphc_pkg::REG_START_DOC, first);
    set_reg(sphc_pkg::REG_END_DOC, stop);
    set_reg(sphc_pkg::REG_HITS_PER_SEGMENT, cap);
    set_reg(sphc_pkg::REG_SEGMENT_COUNT, {25'd0, count});
  endtask

  // With reset settings, documents flow as if a pass had begun at zero.
  task automatic test_before_any_pass();
    send_doc(32'd0, 32'h0000_0000);
    send_doc(32'd5, 32'hFFFF_FFFF);
    send_cmd(sphc_pkg::CMD_UNUSED);
    send_doc(sphc_pkg::U32_MAX, 32'hA5A5_5A5A);
    send_doc(32'd7, 32'h1234_5678);
  endtask

  // Fill every table entry so that no later pass reads an unwritten one.
  task automatic test_table_load();
    for (int i = 0; i < MAX_SEG; i++) begin
      send_word(sphc_pkg::CMD_WRITE_ENTRY, 6'(i), $urandom, $urandom, $urandom);
    end
  endtask

  // Segment caps, skips to the next start, and the hit taken past end_doc after a skip.
  task automatic test_segment_skips();
    set_pass_regs(32'd100, 32'd1000, 32'd2, 7'd3);
    send_word(sphc_pkg::CMD_WRITE_ENTRY, 6'd0, 32'd120, $urandom, $urandom);
    send_word(sphc_pkg::CMD_WRITE_ENTRY, 6'd1, 32'd200, $urandom, $urandom);
    send_word(sphc_pkg::CMD_WRITE_ENTRY, 6'd2, 32'd300, $urandom, $urandom);
    send_cmd(sphc_pkg::CMD_BEGIN_PASS);
    send_doc(32'd90, $urandom);
    send_doc(32'd100, $urandom);
    send_doc(32'd121, $urandom);
    send_doc(32'd122, $urandom);
    send_doc(32'd130, $urandom);
    send_doc(32'd250, $urandom);
    send_doc(32'd260, $urandom);
    send_doc(32'd270, $urandom);
    send_doc(32'd1200, $urandom);
    send_doc(32'd1300, $urandom);
    send_doc(32'd1400, $urandom);
  endtask

  // Registers at their limits, including a segment count above the table size.
  task automatic test_register_extremes();
    set_pass_regs(32'd0, 32'd0, 32'd0, 7'd127);
    send_cmd(sphc_pkg::CMD_BEGIN_PASS);
    send_doc(32'd0, $urandom);
    set_pass_regs(sphc_pkg::U32_MAX - 32'd2, sphc_pkg::U32_MAX, 32'd0, 7'd0);
    send_cmd(sphc_pkg::CMD_BEGIN_PASS);
    send_doc(sphc_pkg::U32_MAX - 32'd3, $urandom);
    send_doc(sphc_pkg::U32_MAX - 32'd2, 32'h0000_0000);
    send_doc(sphc_pkg::U32_MAX - 32'd1, 32'hFFFF_FFFF);
    send_doc(sphc_pkg::U32_MAX, $urandom);
  endtask

  // Mostly well-formed passes with random settings, with some noise mixed in.
  task automatic run_random_passes(input int words, input int src_pct, input int sink_pct);
    int goal;
    int live;
    int loads;
    int docs;
    int roll;
    logic [31:0] base;
    logic [31:0] first;
    logic [31:0] stop;
    logic [31:0] cap;
    logic [6:0] count;
    logic [31:0] entry;
    logic [31:0] doc;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    goal = words_sent + words;
    while (words_sent < goal) begin
      case ($urandom_range(4))
        0: base = 32'd0;
        1: base = sphc_pkg::U32_MAX - 32'd1000;
        default: base = $urandom_range(sphc_pkg::U32_MAX - 32'd1000, 0);
      endcase
      first = base + $urandom_range(0, 40);
      roll = $urandom_range(99);
      if (roll < 10) stop = sat_sub(first, $urandom_range(0, 20));
      else if (roll < 25) stop = sphc_pkg::U32_MAX;
      else stop = sat_add(first, $urandom_range(50, 700));
      roll = $urandom_range(99);
      if (roll < 20) cap = 32'd0;
      else if (roll < 60) cap = $urandom_range(1, 3);
      else if (roll < 80) cap = $urandom_range(4, 10);
      else if (roll < 90) cap = sphc_pkg::U32_MAX;
      else cap = $urandom;
      roll = $urandom_range(99);
      if (roll < 20) count = 7'd0;
      else if (roll < 80) count = 7'($urandom_range(1, 8));
      else if (roll < 90) count = 7'd64;
      else count = 7'($urandom_range(65, 127));
      set_pass_regs(first, stop, cap, count);

      // Load ascending segment starts; deeper entries keep older contents.
      live = (count > MAX_SEG) ? MAX_SEG : int'(count);
      loads = (live > 12) ? 12 : live;
      if (live == MAX_SEG && $urandom_range(3) == 0) loads = MAX_SEG;
      entry = sat_add(base, $urandom_range(0, 60));
      for (int i = 0; i < loads; i++) begin
        send_word(sphc_pkg::CMD_WRITE_ENTRY, 6'(i), entry, $urandom, $urandom);
        entry = sat_add(entry, $urandom_range(0, 90));
      end
      if ($urandom_range(9) != 0) send_cmd(sphc_pkg::CMD_BEGIN_PASS);

      doc = sat_sub(first, $urandom_range(0, 30));
      docs = $urandom_range(12, 40);
      for (int i = 0; i < docs; i++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_cmd(sphc_pkg::CMD_UNUSED);
        end else if (roll < 6) begin
          send_word(sphc_pkg::CMD_WRITE_ENTRY, 6'($urandom_range(63)),
                    sat_add(doc, $urandom_range(0, 80)), $urandom, $urandom);
        end else begin
          if (roll < 10) doc = sat_sub(doc, $urandom_range(0, 40));
          else if (roll < 13) doc = sat_add(doc, $urandom_range(100, 400));
          else doc = sat_add(doc, $urandom_range(0, 14));
          send_doc(doc, $urandom);
        end
      end
    end
  endtask

  // Compare each hit with the oldest expectation.
  always @(posedge clk) begin : check_hits
    logic [63:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected hit, expected none, actual doc %h score %h",
                 $time, m_tdata[31:0], m_tdata[63:32]);
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        if (m_tdata[31:0] !== want[31:0]) begin
          $display("%0t: hit_doc mismatch, expected %h, actual %h",
                   $time, want[31:0], m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[63:32] !== want[63:32]) begin
          $display("%0t: hit_score mismatch, expected %h, actual %h",
                   $time, want[63:32], m_tdata[63:32]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < MAX_SEG; i++) seg_start_m[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_before_any_pass();
    test_table_load();
    test_segment_skips();
    test_register_extremes();
    run_random_passes(550, 10, 50);
    run_random_passes(550, 50, 10);
    run_random_passes(550, 0, 0);

    // Drain the remaining hits and let the unit go quiet.
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
